// ===== hdl/dpst_pkg.sv =====
// Shared types, codes and constants of the dual PID steering block.
// Used by every module under hdl; depends on nothing else.
package dpst_pkg;

  localparam int GAIN_W   = 16;
  localparam int Q_W      = 16;
  localparam int DIFF_W   = Q_W + 1;
  localparam int SUM_W    = 24;
  localparam int STOP_W   = 15;
  localparam int LIMIT_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W    = 43;

  localparam logic signed [Q_W-1:0] Q_MAX       = 16'sh7FFF;
  localparam logic signed [Q_W-1:0] Q_MIN       = 16'sh8000;
  localparam logic signed [Q_W-1:0] CREEP_SPEED = -16'sd410;
  localparam logic [LIMIT_W-1:0]    COUNT_MAX   = 8'd255;

  typedef enum logic [1:0] {
    ST_APPROACH = 2'd0,
    ST_DONE     = 2'd1,
    ST_LOST     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAT_KP    = 3'd0,
    REG_LAT_KI    = 3'd1,
    REG_LAT_KD    = 3'd2,
    REG_ANG_KP    = 3'd3,
    REG_ANG_KI    = 3'd4,
    REG_ANG_KD    = 3'd5,
    REG_STOP_DIST = 3'd6,
    REG_LOSS_LIM  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  lat_kp;
    logic [GAIN_W-1:0]  lat_ki;
    logic [GAIN_W-1:0]  lat_kd;
    logic [GAIN_W-1:0]  ang_kp;
    logic [GAIN_W-1:0]  ang_ki;
    logic [GAIN_W-1:0]  ang_kd;
    logic [STOP_W-1:0]  stop_distance;
    logic [LIMIT_W-1:0] loss_limit;
  } cfg_t;

  typedef struct packed {
    logic                  op;
    logic signed [Q_W-1:0] fwd_distance;
    logic signed [Q_W-1:0] lat_offset;
    logic signed [Q_W-1:0] heading;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] turn_rate;
    logic signed [Q_W-1:0] fwd_speed;
    status_t               status;
  } out_t;

  // Operands of one request handed from the control stage to the MAC stage.
  typedef struct packed {
    logic                     drive;
    status_t                  status;
    logic signed [Q_W-1:0]    e_lat;
    logic signed [DIFF_W-1:0] d_lat;
    logic signed [SUM_W-1:0]  s_lat;
    logic signed [Q_W-1:0]    e_ang;
    logic signed [DIFF_W-1:0] d_ang;
    logic signed [SUM_W-1:0]  s_ang;
  } oper_t;

endpackage

// ===== hdl/dpst_cfg.sv =====
// Configuration register file of the dual PID steering block.
// Depends on dpst_pkg.
module dpst_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dpst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpst_pkg::GAIN_W-1:0]     cfg_data,
  output dpst_pkg::cfg_t                  cfg
);
  import dpst_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lat_kp        <= 16'd819;
      cfg.lat_ki        <= 16'd20;
      cfg.lat_kd        <= 16'd20480;
      cfg.ang_kp        <= 16'd2458;
      cfg.ang_ki        <= 16'd0;
      cfg.ang_kd        <= 16'd20480;
      cfg.stop_distance <= 15'd2458;
      cfg.loss_limit    <= 8'd50;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_LAT_KP:    cfg.lat_kp        <= cfg_data;
        REG_LAT_KI:    cfg.lat_ki        <= cfg_data;
        REG_LAT_KD:    cfg.lat_kd        <= cfg_data;
        REG_ANG_KP:    cfg.ang_kp        <= cfg_data;
        REG_ANG_KI:    cfg.ang_ki        <= cfg_data;
        REG_ANG_KD:    cfg.ang_kd        <= cfg_data;
        REG_STOP_DIST: cfg.stop_distance <= cfg_data[STOP_W-1:0];
        REG_LOSS_LIM:  cfg.loss_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/dpst_ctrl.sv =====
// Control stage: errors, integral sums, loss timeout and finish state.
// Registers the PID operands of each request. Depends on dpst_pkg.
module dpst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  dpst_pkg::cfg_t cfg,
  input  dpst_pkg::in_t  req,
  input  logic           take,
  output dpst_pkg::oper_t oper
);
  import dpst_pkg::*;

  logic signed [Q_W-1:0]   prev_lat_err, prev_lat_err_next;
  logic signed [Q_W-1:0]   prev_ang_err, prev_ang_err_next;
  logic signed [SUM_W-1:0] lat_err_sum, lat_err_sum_next;
  logic signed [SUM_W-1:0] ang_err_sum, ang_err_sum_next;
  logic signed [Q_W-1:0]   last_distance, last_distance_next;
  logic [LIMIT_W-1:0]      stall_count, stall_count_next;
  status_t                 finish, finish_next;
  oper_t                   oper_next;

  logic signed [Q_W-1:0] e_lat;
  logic [LIMIT_W-1:0]    count_inc;
  logic                  close;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] s,
    input logic signed [Q_W-1:0]   e
  );
    logic [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W+1-Q_W){e[Q_W-1]}}, e};
    if (t[SUM_W] != t[SUM_W-1]) begin
      sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = t[SUM_W-1:0];
    end
  endfunction

  always_comb begin
    e_lat     = (req.lat_offset == Q_MIN) ? Q_MAX : -req.lat_offset;
    close     = req.fwd_distance <= $signed({1'b0, cfg.stop_distance});
    count_inc = (stall_count == COUNT_MAX) ? COUNT_MAX : stall_count + 8'd1;

    prev_lat_err_next  = prev_lat_err;
    prev_ang_err_next  = prev_ang_err;
    lat_err_sum_next   = lat_err_sum;
    ang_err_sum_next   = ang_err_sum;
    last_distance_next = last_distance;
    stall_count_next   = stall_count;
    finish_next        = finish;

    oper_next.drive  = 1'b0;
    oper_next.status = finish;
    oper_next.e_lat  = e_lat;
    oper_next.d_lat  = {e_lat[Q_W-1], e_lat} - {prev_lat_err[Q_W-1], prev_lat_err};
    oper_next.s_lat  = lat_err_sum;
    oper_next.e_ang  = req.heading;
    oper_next.d_ang  = {req.heading[Q_W-1], req.heading} - {prev_ang_err[Q_W-1], prev_ang_err};
    oper_next.s_ang  = ang_err_sum;

    if (req.op) begin
      // restart: clear all controller state
      prev_lat_err_next  = '0;
      prev_ang_err_next  = '0;
      lat_err_sum_next   = '0;
      ang_err_sum_next   = '0;
      last_distance_next = '0;
      stall_count_next   = '0;
      finish_next        = ST_APPROACH;
      oper_next.status   = ST_APPROACH;
    end else if (finish != ST_APPROACH) begin
      // finished: hold state, report the finish status
    end else if (close) begin
      finish_next      = ST_DONE;
      oper_next.status = ST_DONE;
    end else begin
      prev_lat_err_next = e_lat;
      prev_ang_err_next = req.heading;
      lat_err_sum_next  = sat_add(lat_err_sum, e_lat);
      ang_err_sum_next  = sat_add(ang_err_sum, req.heading);
      if (req.fwd_distance == last_distance) begin
        stall_count_next = count_inc;
        if (count_inc >= cfg.loss_limit) begin
          finish_next      = ST_LOST;
          oper_next.status = ST_LOST;
        end else begin
          oper_next.drive = 1'b1;
        end
      end else begin
        stall_count_next   = '0;
        last_distance_next = req.fwd_distance;
        oper_next.drive    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lat_err  <= '0;
      prev_ang_err  <= '0;
      lat_err_sum   <= '0;
      ang_err_sum   <= '0;
      last_distance <= '0;
      stall_count   <= '0;
      finish        <= ST_APPROACH;
    end else if (take) begin
      prev_lat_err  <= prev_lat_err_next;
      prev_ang_err  <= prev_ang_err_next;
      lat_err_sum   <= lat_err_sum_next;
      ang_err_sum   <= ang_err_sum_next;
      last_distance <= last_distance_next;
      stall_count   <= stall_count_next;
      finish        <= finish_next;
    end
    if (take) begin
      oper <= oper_next;
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    take && req.op |=> finish == ST_APPROACH && stall_count == '0 &&
                       lat_err_sum == '0 && ang_err_sum == '0)
    else $error("restart left controller state behind");

  a_stop_latches: assert property (@(posedge clk) disable iff (rst)
    take && !req.op && finish == ST_APPROACH && close |=> finish == ST_DONE)
    else $error("stop distance did not latch done");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    finish != ST_APPROACH && !(take && req.op) |=>
      finish == $past(finish) && lat_err_sum == $past(lat_err_sum) &&
      ang_err_sum == $past(ang_err_sum))
    else $error("state changed after finish");

endmodule

// ===== hdl/dpst_mac.sv =====
// MAC stage: six gain products, registered, then summed, rounded and saturated.
// Depends on dpst_pkg.
module dpst_mac (
  input  logic            clk,
  input  logic            load,
  input  dpst_pkg::cfg_t  cfg,
  input  dpst_pkg::oper_t oper,
  output dpst_pkg::out_t  result
);
  import dpst_pkg::*;

  localparam int PP_W = GAIN_W + 1 + Q_W;
  localparam int PD_W = GAIN_W + 1 + DIFF_W;
  localparam int PI_W = GAIN_W + 1 + SUM_W;
  localparam int RQ_W = ACC_W - 12;

  typedef struct packed {
    logic                   drive;
    status_t                status;
    logic signed [PP_W-1:0] lat_p;
    logic signed [PD_W-1:0] lat_d;
    logic signed [PI_W-1:0] lat_i;
    logic signed [PP_W-1:0] ang_p;
    logic signed [PD_W-1:0] ang_d;
    logic signed [PI_W-1:0] ang_i;
  } prod_t;

  prod_t prod;

  logic signed [ACC_W-1:0] acc;
  logic signed [RQ_W-1:0]  q;
  logic signed [Q_W-1:0]   turn;

  always_ff @(posedge clk) begin
    if (load) begin
      prod.drive  <= oper.drive;
      prod.status <= oper.status;
      prod.lat_p  <= $signed({1'b0, cfg.lat_kp}) * oper.e_lat;
      prod.lat_d  <= $signed({1'b0, cfg.lat_kd}) * oper.d_lat;
      prod.lat_i  <= $signed({1'b0, cfg.lat_ki}) * oper.s_lat;
      prod.ang_p  <= $signed({1'b0, cfg.ang_kp}) * oper.e_ang;
      prod.ang_d  <= $signed({1'b0, cfg.ang_kd}) * oper.d_ang;
      prod.ang_i  <= $signed({1'b0, cfg.ang_ki}) * oper.s_ang;
    end
  end

  always_comb begin
    acc = ACC_W'(prod.lat_p) + ACC_W'(prod.lat_d) + ACC_W'(prod.lat_i) +
          ACC_W'(prod.ang_p) + ACC_W'(prod.ang_d) + ACC_W'(prod.ang_i);
    // round half up to Q3.12: add half an LSB, then floor
    q = RQ_W'((acc + ACC_W'(2048)) >>> 12);
    if (q > RQ_W'(Q_MAX)) begin
      turn = Q_MAX;
    end else if (q < RQ_W'(Q_MIN)) begin
      turn = Q_MIN;
    end else begin
      turn = q[Q_W-1:0];
    end
    result.turn_rate = prod.drive ? turn : '0;
    result.fwd_speed = prod.drive ? CREEP_SPEED : '0;
    result.status    = prod.status;
  end

endmodule

// ===== hdl/dual_pid_steering_with_loss_timeout.sv =====
// Dual PID steering controller with target-loss timeout, top level.
// Depends on dpst_pkg, dpst_cfg, dpst_ctrl and dpst_mac.
//
// One request is one control tick (or a restart) and yields exactly one
// result. The block takes a request in every cycle unless in_stall is high:
// it is a four-register pipeline (input register, control stage with the
// controller state, product register, output register), which a request
// passes in that order, and the sustained rate is one request per cycle
// while the output does not stall. The controller state (previous errors,
// integral sums, last distance, stall count, finish state) is read and
// updated in the control stage, so consecutive ticks see each other's
// updates with no gap. A stall on the output backs up the stages one by one;
// in_stall rises only when all four stages hold a request. Configuration
// registers are read live, so write them only while no request is in flight.
module dual_pid_steering_with_loss_timeout (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dpst_pkg::in_t                  in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output dpst_pkg::out_t                 out_data,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [dpst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpst_pkg::GAIN_W-1:0]    cfg_data
);
  import dpst_pkg::*;

  cfg_t  cfg;
  in_t   req;
  oper_t oper;
  out_t  result;

  // stage valid bits: input register, operand register, product register
  logic v1, v2, v3;
  // a stage may load when it is empty or its content moves on this cycle
  logic rdy_out, rdy3, rdy2, rdy1;

  assign rdy_out  = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  dpst_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // control stage advances the controller state once per request
  dpst_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .req  (req),
    .take (v1 && rdy2),
    .oper (oper)
  );

  dpst_mac u_mac (
    .clk    (clk),
    .load   (v2 && rdy3),
    .cfg    (cfg),
    .oper   (oper),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_out) begin
        out_valid <= v3;
      end
    end
    // payload: capture the request, hold the result until taken
    if (rdy1 && in_valid) begin
      req <= in_data;
    end
    if (rdy_out && v3) begin
      out_data <= result;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3 && out_valid && out_stall)
    else $error("request stalled with a free stage");

  a_finished_is_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_APPROACH |->
      out_data.turn_rate == '0 && out_data.fwd_speed == '0)
    else $error("motion commanded with done or lost status");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

endmodule

// ===== tb/dual_pid_steering_with_loss_timeout_test.sv =====
// Self-checking testbench for the dual PID steering block: directed table, then random
// approach runs under several gain/limit settings, scored against an in-bench predictor.
// Depends on dpst_pkg and the dual_pid_steering_with_loss_timeout top level only.
module dual_pid_steering_with_loss_timeout_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dpst_pkg::*;

  localparam int QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
  localparam int REPORT_MAX  = 10;
  localparam int LONG_HOLD   = 80;     // receiver hold-off that backs up the pipeline
  localparam bit BY_MODEL    = 1'b0;   // row checked against the predictor
  localparam bit TYPED       = 1'b1;   // row carries its own expected status

  localparam cfg_t RESET_SETTINGS = '{16'd819, 16'd20, 16'd20480, 16'd2458, 16'd0,
                                      16'd20480, 15'd2458, 8'd50};

  // One directed row. Typed rows always expect zero turn and zero speed.
  typedef struct packed {
    bit                 typed;
    status_t            want;
    logic               op;
    logic signed [15:0] distance;
    logic signed [15:0] lat;
    logic signed [15:0] hdg;
  } row_t;

  // Directed part runs with reset gains, reset stop distance and a loss limit of 3.
  localparam row_t DIRECTED [20] = '{
    '{TYPED,    ST_APPROACH, 1'b1, 16'sh1234,   16'shABCD,   16'sh5A5A},  // restart, junk
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sh7FFF,   16'sh8000,   16'sh7FFF},  // negated min offset
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sh7FFF,   16'sh7FFF,   16'sh8000},  // same distance, 1
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sh7FFF,   16'sh0000,   16'sh0000},  // same distance, 2
    '{TYPED,    ST_LOST,     1'b0, 16'sh7FFF,   16'sh0001,   16'shFFFF},  // hits loss limit
    '{TYPED,    ST_LOST,     1'b0, 16'sd100,    16'sh0000,   16'sh0000},  // lost is held
    '{TYPED,    ST_APPROACH, 1'b1, 16'sh0000,   16'sh0000,   16'sh0000},
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sd2459,   16'sh8000,   16'sh8000},  // just above stop
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sd4000,   -16'sd5000,  16'sd3000},
    '{TYPED,    ST_DONE,     1'b0, 16'sd2458,   16'sh0000,   16'sh0000},  // exactly at stop
    '{TYPED,    ST_DONE,     1'b0, 16'sh7FFF,   16'sh7FFF,   16'sh7FFF},  // done is held
    '{TYPED,    ST_APPROACH, 1'b1, 16'shFFFF,   16'shFFFF,   16'shFFFF},
    '{TYPED,    ST_DONE,     1'b0, 16'sh8000,   16'sh0000,   16'sh0000},  // min distance
    '{TYPED,    ST_APPROACH, 1'b1, 16'sh0000,   16'sh0000,   16'sh0000},
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sd2459,   16'sd100,    -16'sd100},
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sd4000,   -16'sd32767, 16'sh7FFF},
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sd3000,   16'sh7FFF,   16'sh8000},
    '{TYPED,    ST_DONE,     1'b0, 16'shFFFE,   16'sh1111,   16'sh2222},  // negative distance
    '{TYPED,    ST_APPROACH, 1'b1, 16'sh0000,   16'sh0000,   16'sh0000},
    '{BY_MODEL, ST_APPROACH, 1'b0, 16'sd5000,   16'sh0000,   16'sh0000}
  };

  // Cumulative request counts at which each random phase ends.
  localparam int PHASES = 8;
  localparam int PHASE_END [PHASES] = '{270, 520, 770, 830, 1130, 1380, 1630, 1870};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;

  dual_pid_steering_with_loss_timeout uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the register file and controller state.
  cfg_t    model_cfg;
  int      prev_lat_err;
  int      prev_ang_err;
  int      lat_err_sum;
  int      ang_err_sum;
  int      last_dist;
  int      stall_ticks;
  status_t finish_st;

  out_t expected_cmds[$];   // turn/speed/status commands still owed by the block

  int  errors;
  int  requests_sent;
  int  results_checked;
  int  done_seen;
  int  lost_seen;
  int  settings_used;
  bit  no_idle;             // both sides run back to back while set
  bit  took_result;         // handshake seen on the result channel at the last edge
  int  hold_left;
  int  quiet_cycles;

  // Clock: 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_controller();
    prev_lat_err = 0;
    prev_ang_err = 0;
    lat_err_sum  = 0;
    ang_err_sum  = 0;
    last_dist    = 0;
    stall_ticks  = 0;
    finish_st    = ST_APPROACH;
  endfunction

  // Integral accumulators saturate at 24 bits signed.
  function automatic int clamp_sum(int v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Work out the command for one request and advance the controller state.
  function automatic out_t predict_command(in_t req);
    out_t   res;
    int     distance;
    int     e_lat;
    int     e_ang;
    longint acc;
    longint q;
    res.turn_rate = '0;
    res.fwd_speed = '0;
    res.status    = ST_APPROACH;
    if (req.op) begin
      clear_controller();
      return res;
    end
    // Hold everything once the approach has ended.
    if (finish_st != ST_APPROACH) begin
      res.status = finish_st;
      return res;
    end
    distance = $signed(req.fwd_distance);
    if (distance <= int'(model_cfg.stop_distance)) begin
      finish_st  = ST_DONE;
      res.status = ST_DONE;
      return res;
    end
    // Negating the most negative offset clips to the positive maximum.
    e_lat = -int'($signed(req.lat_offset));
    if (e_lat > 32767) e_lat = 32767;
    e_ang = $signed(req.heading);
    // Q4.12 gains times Q3.12 operands, summed exactly at Q.24.
    acc = longint'(model_cfg.lat_kp) * e_lat
        + longint'(model_cfg.lat_kd) * (e_lat - prev_lat_err)
        + longint'(model_cfg.lat_ki) * lat_err_sum
        + longint'(model_cfg.ang_kp) * e_ang
        + longint'(model_cfg.ang_kd) * (e_ang - prev_ang_err)
        + longint'(model_cfg.ang_ki) * ang_err_sum;
    // Round half up back to Q3.12, then clip to 16 bits.
    q = (acc + 2048) >>> 12;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    prev_lat_err = e_lat;
    prev_ang_err = e_ang;
    lat_err_sum  = clamp_sum(lat_err_sum + e_lat);
    ang_err_sum  = clamp_sum(ang_err_sum + e_ang);
    if (distance == last_dist) begin
      if (stall_ticks < 255) stall_ticks++;
      if (stall_ticks >= int'(model_cfg.loss_limit)) begin
        finish_st  = ST_LOST;
        res.status = ST_LOST;
        return res;
      end
    end else begin
      stall_ticks = 0;
      last_dist   = distance;
    end
    res.turn_rate = 16'(q);
    res.fwd_speed = CREEP_SPEED;
    return res;
  endfunction

  // Now and then the extremes or small values near zero, mostly raw random words.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 400) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t make_tick(int distance);
    in_t t;
    t.op           = 1'b0;
    t.fwd_distance = 16'(distance);
    t.lat_offset   = pick_value();
    t.heading      = pick_value();
    return t;
  endfunction

  function automatic logic [15:0] random_gain();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 4096));
  endfunction

  // Enter and leave at a falling edge. Hold the request until the block takes it,
  // then predict its command. A following call at the same edge replaces the
  // payload in place, so valid is never dropped and raised within one step.
  task automatic send_request(input in_t req, input bit typed, input status_t want);
    int   gap;
    out_t pred;
    out_t fixed;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    pred = predict_command(req);
    fixed.turn_rate = '0;
    fixed.fwd_speed = '0;
    fixed.status    = want;
    expected_cmds.push_back(typed ? fixed : pred);
    requests_sent++;
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_LAT_KP:    model_cfg.lat_kp = value;
      REG_LAT_KI:    model_cfg.lat_ki = value;
      REG_LAT_KD:    model_cfg.lat_kd = value;
      REG_ANG_KP:    model_cfg.ang_kp = value;
      REG_ANG_KI:    model_cfg.ang_ki = value;
      REG_ANG_KD:    model_cfg.ang_kd = value;
      REG_STOP_DIST: model_cfg.stop_distance = value[STOP_W-1:0];
      REG_LOSS_LIM:  model_cfg.loss_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Registers are read live: drain every owed command, let the pipeline settle,
  // then load the whole set.
  task automatic apply_settings(input cfg_t s);
    in_valid = 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_register(REG_LAT_KP, s.lat_kp);
    write_register(REG_LAT_KI, s.lat_ki);
    write_register(REG_LAT_KD, s.lat_kd);
    write_register(REG_ANG_KP, s.ang_kp);
    write_register(REG_ANG_KI, s.ang_ki);
    write_register(REG_ANG_KD, s.ang_kd);
    write_register(REG_STOP_DIST, {1'b0, s.stop_distance});
    write_register(REG_LOSS_LIM, {8'd0, s.loss_limit});
    settings_used++;
  endtask

  // One approach: restart (usually), close in on the target with random steering
  // input, sometimes repeat the distance long enough to lose the target, and poke
  // a few ticks after the approach has ended.
  task automatic approach_run(input int limit);
    int  distance;
    int  reps;
    int  stop;
    in_t noise;
    no_idle = ($urandom_range(0, 3) == 0);
    stop    = model_cfg.stop_distance;
    if ($urandom_range(0, 9) != 0) begin
      noise = '{1'b1, 16'($urandom), 16'($urandom), 16'($urandom)};
      send_request(noise, BY_MODEL, ST_APPROACH);
    end
    distance = (stop >= 32767) ? int'($urandom_range(0, 65535)) - 32768
                               : int'($urandom_range(stop + 1, 32767));
    while (requests_sent < limit && finish_st == ST_APPROACH) begin
      reps = 1;
      if ($urandom_range(0, 9) == 0)
        reps = ($urandom_range(0, 3) == 0) ? int'(model_cfg.loss_limit) + 1
                                           : int'($urandom_range(2, 4));
      repeat (reps) begin
        if (requests_sent < limit) send_request(make_tick(distance), BY_MODEL, ST_APPROACH);
      end
      distance -= $urandom_range(1, 3000);
      if (distance < -32768) distance = -32768;
      // Occasional stray request: any distance, and now and then a restart.
      if ($urandom_range(0, 19) == 0) begin
        noise.op           = ($urandom_range(0, 7) == 0);
        noise.fwd_distance = 16'($urandom);
        noise.lat_offset   = 16'($urandom);
        noise.heading      = 16'($urandom);
        send_request(noise, BY_MODEL, ST_APPROACH);
      end
    end
    repeat ($urandom_range(0, 2))
      send_request(make_tick(int'($urandom_range(0, 65535)) - 32768), BY_MODEL, ST_APPROACH);
  endtask

  // Result side: take each command, compare it field by field with the oldest owed one.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      took_result = 1'b1;
      results_checked++;
      if (out_data.status == ST_DONE) done_seen++;
      if (out_data.status == ST_LOST) lost_seen++;
      if (expected_cmds.size() == 0) begin
        if (errors < REPORT_MAX)
          $display("MISMATCH: unexpected command turn %0d speed %0d status %0d",
                   out_data.turn_rate, out_data.fwd_speed, out_data.status);
        errors++;
      end else begin
        want = expected_cmds.pop_front();
        if (out_data.turn_rate !== want.turn_rate || out_data.fwd_speed !== want.fwd_speed ||
            out_data.status !== want.status) begin
          if (errors < REPORT_MAX) begin
            $write("MISMATCH at result %0d: expected turn %0d speed %0d status %0d, ",
                   results_checked, want.turn_rate, want.fwd_speed, want.status);
            $display("got turn %0d speed %0d status %0d",
                     out_data.turn_rate, out_data.fwd_speed, out_data.status);
          end
          errors++;
        end
      end
    end
  end

  // Result side stall: a random hold-off before each command, none in a no-idle stretch,
  // and twice hold off long enough that the pipeline fills and stalls the request side.
  always @(negedge clk) begin
    if (took_result) begin
      took_result = 1'b0;
      if (results_checked == 400 || results_checked == 1300) hold_left = LONG_HOLD;
      else hold_left = no_idle ? 0 : $urandom_range(0, 5);
    end
    out_stall = (hold_left > 0);
    if (hold_left > 0) hold_left--;
  end

  // Watchdog: give up after a long stretch with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d commands still owed",
               QUIET_LIMIT, expected_cmds.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cfg_t s;
    in_t  req;
    // Drive every input to a known value from time zero.
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    errors      = 0;
    no_idle     = 1'b0;
    took_result = 1'b0;
    hold_left   = 0;
    model_cfg   = RESET_SETTINGS;
    clear_controller();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: reset gains and stop distance, short loss limit so the lost
    // case is reached within a handful of rows.
    write_register(REG_LOSS_LIM, 16'd3);
    foreach (DIRECTED[i]) begin
      req = '{DIRECTED[i].op, DIRECTED[i].distance, DIRECTED[i].lat, DIRECTED[i].hdg};
      send_request(req, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases, each under its own register settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = RESET_SETTINGS;
        1: s = '0;                                              // all gains off, limit zero
        2: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd0, 8'd1};
        3: s = '{random_gain(), random_gain(), random_gain(), random_gain(), random_gain(),
                 random_gain(), 15'h7FFF, 8'd255};            // everything counts as done
        4: s = '{16'd819, 16'd20, 16'd20480, 16'd2458, 16'd16, 16'd20480, 15'd0, 8'd255};
        default:
          s = '{random_gain(), random_gain(), random_gain(), random_gain(), random_gain(),
                random_gain(), 15'($urandom_range(0, 8192)), 8'($urandom_range(1, 20))};
      endcase
      apply_settings(s);
      if (p == 4) begin
        // One long uninterrupted approach with maximum error, so both integral
        // sums run into their 24-bit clip.
        no_idle = 1'b1;
        req = '{1'b1, 16'h0, 16'h0, 16'h0};
        send_request(req, BY_MODEL, ST_APPROACH);
        for (int k = 0; k < 300; k++) begin
          req = '{1'b0, 16'(30000 - 90 * k), (k < 280) ? 16'sh8000 : 16'sh0100, 16'sh7FFF};
          send_request(req, BY_MODEL, ST_APPROACH);
        end
      end
      while (requests_sent < PHASE_END[p]) approach_run(PHASE_END[p]);
    end

    // Drain, then give the pipeline time to show any stray extra command.
    in_valid = 1'b0;
    no_idle  = 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    errors += expected_cmds.size();

    $display("Run covered %0d requests under %0d register settings plus the directed table;",
             requests_sent, settings_used);
    $display("%0d commands checked, %0d with status done, %0d with target lost, %0d errors.",
             results_checked, done_seen, lost_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== dual_pid_steering_with_loss_timeout.f =====
hdl/dpst_pkg.sv
hdl/dpst_cfg.sv
hdl/dpst_ctrl.sv
hdl/dpst_mac.sv
hdl/dual_pid_steering_with_loss_timeout.sv
tb/dual_pid_steering_with_loss_timeout_test.sv
